>>> design/bia_pkg.sv
// Shared constants, codes and controller/datapath types for the bitmap ID allocator.
`timescale 1ns / 1ps
`default_nettype none
package bia_pkg;

    localparam int NUM_IDS   = 1024;
    localparam int WORD_BITS = 64;
    localparam int MAP_WORDS = (NUM_IDS + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_AW    = $clog2(WORD_BITS);

    localparam int ID_W      = 10;
    localparam int STATUS_W  = 2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_WAS_FREE = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture the input item, set first word address
        logic adv;       // step the scan read address
        logic check;     // evaluate the word at the RAM output
        logic out_load;  // move the pending result into the output register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic chk_done;  // current check settles the item
    } t_dp_stat;

endpackage
`default_nettype wire

>>> design/bia_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bia_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

>>> design/bia_datapath.sv
// Datapath: bitmap RAM, row valid bits, scan address, first-free search and result registers.
`timescale 1ns / 1ps
`default_nettype none
module bia_datapath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire bia_pkg::t_dp_cmd              i_cmd,
    output bia_pkg::t_dp_stat                  o_stat,
    input  wire logic                          i_command,
    input  wire logic [bia_pkg::ID_W-1:0]      i_logic_id,
    output logic      [bia_pkg::ID_W-1:0]      o_granted_id,
    output logic      [bia_pkg::STATUS_W-1:0]  o_status
);
    import bia_pkg::*;

    logic                 r_cmd;
    logic [ID_W-1:0]      r_lid;
    logic [WORD_AW-1:0]   r_rd_addr;
    logic [WORD_AW-1:0]   r_chk_addr;
    logic [MAP_WORDS-1:0] r_row_valid;
    logic [ID_W-1:0]      r_pend_gid;
    logic [STATUS_W-1:0]  r_pend_st;

    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] word;
    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_AW-1:0]    bpos;
    logic                 found;
    logic [31:0]          alloc_id;
    logic                 alloc_ok;
    logic                 last_word;
    logic                 lid_in_range;
    logic                 lid_used;
    logic                 we;
    logic [WORD_BITS-1:0] wdata;
    logic [ID_W-1:0]      n_pend_gid;
    logic [STATUS_W-1:0]  n_pend_st;

    bia_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_chk_addr),
        .i_wdata (wdata),
        .i_raddr (r_rd_addr),
        .o_rdata (ram_rdata)
    );

    // a row never written reads as all free
    assign word      = r_row_valid[r_chk_addr] ? ram_rdata : '0;
    assign free_bits = ~word;

    // lowest free bit of the word
    always_comb begin
        bpos = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (free_bits[b]) begin
                bpos = BIT_AW'(b);
            end
        end
    end

    assign found        = |free_bits;
    assign alloc_id     = 32'({r_chk_addr, bpos});
    assign alloc_ok     = found && (alloc_id < 32'(NUM_IDS));
    assign last_word    = (r_chk_addr == WORD_AW'(MAP_WORDS - 1));
    assign lid_in_range = (32'(r_lid) < 32'(NUM_IDS));
    assign lid_used     = word[r_lid[BIT_AW-1:0]];

    always_comb begin
        we         = 1'b0;
        wdata      = word;
        n_pend_gid = '0;
        n_pend_st  = ST_DONE;
        if (r_cmd == CMD_ALLOC) begin
            o_stat.chk_done = found || last_word;
            wdata           = word | (WORD_BITS'(1) << bpos);
            if (alloc_ok) begin
                we         = i_cmd.check;
                n_pend_gid = ID_W'(alloc_id);
            end else begin
                n_pend_st  = ST_FULL;
            end
        end else begin
            o_stat.chk_done = 1'b1;
            wdata           = word & ~(WORD_BITS'(1) << r_lid[BIT_AW-1:0]);
            if (lid_in_range && lid_used) begin
                we = i_cmd.check;
            end else begin
                n_pend_st = ST_WAS_FREE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
        end else if (we) begin
            r_row_valid[r_chk_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_addr <= r_rd_addr;
        if (i_cmd.load) begin
            r_cmd     <= i_command;
            r_lid     <= i_logic_id;
            r_rd_addr <= (i_command == CMD_ALLOC) ? '0 : WORD_AW'(32'(i_logic_id) >> BIT_AW);
        end else if (i_cmd.adv && r_cmd == CMD_ALLOC) begin
            r_rd_addr <= r_rd_addr + WORD_AW'(1);
        end
        if (i_cmd.check && o_stat.chk_done) begin
            r_pend_gid <= n_pend_gid;
            r_pend_st  <= n_pend_st;
        end
        if (i_cmd.out_load) begin
            o_granted_id <= r_pend_gid;
            o_status     <= r_pend_st;
        end
    end

endmodule
`default_nettype wire

>>> design/bia_ctrl.sv
// Controller: sequences accept, word read, scan/check and result hand-off.
`timescale 1ns / 1ps
`default_nettype none
module bia_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output bia_pkg::t_dp_cmd       o_cmd,
    input  wire bia_pkg::t_dp_stat i_stat
);
    import bia_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_CHK,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   slot_free;

    assign slot_free  = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_READ;
                end
            end
            S_READ: begin
                o_cmd.adv = 1'b1;
                n_state   = S_CHK;
            end
            S_CHK: begin
                o_cmd.check = 1'b1;
                o_cmd.adv   = 1'b1;
                if (i_stat.chk_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end
        end
    end

endmodule
`default_nettype wire

>>> design/bitmap_id_allocator.sv
// Top level of the bitmap first-free identifier allocator.
//
// Input channel (i_in_valid / o_in_stall): one item is a command and an
// identifier. Allocate returns the lowest free identifier and marks it used;
// free clears the used bit of i_logic_id. Each item gives exactly one result.
// Output channel (o_out_valid / i_out_stall): granted identifier and status
// (done, no free identifier, identifier already free).
// The used map sits in a 64-bit wide RAM, one word per 64 identifiers.
// Search: a free reads and checks the one word that holds i_logic_id; an
// allocate scans words from word 0 upward until one has a free bit or the
// last word is reached (1 to 16 words), reading one RAM word per cycle
// through the single read port. One item is handled at a time; a new item is
// taken the cycle after the previous result moves to the output register.
// The output register holds a result while i_out_stall is high; the next
// item may be accepted meanwhile and waits for the register to drain.
// Reset: synchronous, active low; every identifier becomes free at once
// through per-word valid bits, so there is no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module bitmap_id_allocator (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic                         i_command,
    input  wire logic [bia_pkg::ID_W-1:0]     i_logic_id,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic      [bia_pkg::ID_W-1:0]     o_granted_id,
    output logic      [bia_pkg::STATUS_W-1:0] o_status
);
    import bia_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    // sequencing: accept, first read, scan/check, result hand-off
    bia_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // bitmap storage, first-free search and result registers
    bia_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_command    (i_command),
        .i_logic_id   (i_logic_id),
        .o_granted_id (o_granted_id),
        .o_status     (o_status)
    );

endmodule
`default_nettype wire

>>> dv/testbench.sv
// Self-checking testbench for the bitmap first-free identifier allocator.
`timescale 1ns / 1ps
module testbench;
    import bia_pkg::*;

    // Clock period, run limit and settling time after the last result.
    localparam int CLK_PERIOD  = 12;
    localparam int RESET_CYCLES = 12;
    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN_CYCLES = 40;
    localparam int RANDOM_ITEMS = 100;

    // One result item: granted identifier and status code.
    typedef struct packed {
        logic [ID_W-1:0]     granted;
        logic [STATUS_W-1:0] status;
    } id_result_t;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_stall;
    logic                command;
    logic [ID_W-1:0]     logic_id;
    logic                out_valid;
    logic                out_stall;
    logic [ID_W-1:0]     granted_id;
    logic [STATUS_W-1:0] status;

    // Predictor state: one used flag per identifier, set means allocated.
    bit         id_used [NUM_IDS];
    id_result_t expected_results [$];

    int mismatches;
    int cycle_count;
    // Idling controls: a quiet side never idles; hold_left is a long receiver hold-off.
    bit send_quiet;
    bit recv_quiet;
    int hold_left;

    bitmap_id_allocator uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_command    (command),
        .i_logic_id   (logic_id),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_granted_id (granted_id),
        .o_status     (status)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Guard against a hung block or a result that never turns up.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Applies one command to the identifier map and returns the result it
    // should produce. Allocate takes the lowest free identifier; free
    // clears a used one, and an already free identifier leaves the map alone.
    function automatic id_result_t predict_result(input logic cmd,
                                                  input logic [ID_W-1:0] id);
        id_result_t res;
        int         slot;
        res.granted = '0;
        res.status  = ST_WAS_FREE;
        if (cmd == CMD_ALLOC) begin
            slot = -1;
            for (int i = 0; i < NUM_IDS && slot < 0; i++) begin
                if (!id_used[i]) slot = i;
            end
            if (slot < 0) begin
                // full map: refusal, nothing changes
                res.status = ST_FULL;
            end else begin
                id_used[slot] = 1'b1;
                res.granted   = slot[ID_W-1:0];
                res.status    = ST_DONE;
            end
        end else if (int'(id) < NUM_IDS && id_used[id]) begin
            id_used[id] = 1'b0;
            res.status  = ST_DONE;
        end
        return res;
    endfunction

    // Mostly a used identifier, so that frees do real work; sometimes any value.
    function automatic logic [ID_W-1:0] pick_free_target();
        logic [ID_W-1:0] id;
        id = ID_W'($urandom);
        if ($urandom_range(0, 3) != 0) begin
            for (int t = 0; t < 64 && !id_used[id]; t++) id = ID_W'($urandom);
        end
        return id;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offers one item and waits for it to be taken. On return, valid is still
    // high unless an idle gap followed, so the caller sends the next item at
    // once or calls stop_sending.
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id);
        int gap;
        in_valid <= 1'b1;
        command  <= cmd;
        logic_id <= id;
        do @(posedge i_clk); while (in_stall);
        expected_results.push_back(predict_result(cmd, id));
        gap = send_quiet ? 0 : pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stalls, quiet stretches and a long hold-off.
    // ------------------------------------------------------------------
    initial begin : drive_out_stall
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (recv_quiet || r < 60) begin
                    out_stall <= 1'b0;
                end else begin
                    stall_left = (r < 95) ? $urandom_range(0, 2) : $urandom_range(9, 39);
                    out_stall <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR at %0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : check_results
        id_result_t want;
        if (i_rst_n && out_valid && !out_stall) begin
            if (expected_results.size() == 0) begin
                report_mismatch("result item with none outstanding, granted_id",
                                int'(granted_id), -1);
            end else begin
                want = expected_results.pop_front();
                if (granted_id !== want.granted)
                    report_mismatch("granted_id", int'(granted_id), int'(want.granted));
                if (status !== want.status)
                    report_mismatch("status", int'(status), int'(want.status));
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Low identifiers, reuse of a freed identifier, double free and the
    // extremes of the identifier field.
    task automatic test_directed();
        send_item(CMD_ALLOC, '0);           // -> 0
        send_item(CMD_ALLOC, '1);           // -> 1, field ignored
        send_item(CMD_ALLOC, 10'h155);      // -> 2
        send_item(CMD_FREE, 10'd1);         // done
        send_item(CMD_FREE, 10'd1);         // already free
        send_item(CMD_ALLOC, 10'h2AA);      // hole at 1 is refilled
        send_item(CMD_FREE, '1);            // top identifier, never used
        send_item(CMD_FREE, '0);            // done
        send_item(CMD_FREE, '0);            // already free
        send_item(CMD_ALLOC, '0);           // -> 0 again
        send_item(CMD_FREE, 10'h155);
        send_item(CMD_FREE, 10'h2AA);
        send_item(CMD_ALLOC, '0);           // -> 3
        send_item(CMD_ALLOC, '1);           // -> 4
        send_item(CMD_FREE, 10'd2);
        send_item(CMD_ALLOC, '0);           // -> 2
        stop_sending();
    endtask

    // The receiver holds off for a long stretch while items keep coming, so
    // the output register fills and the block stalls its input.
    task automatic test_backpressure();
        send_quiet = 1'b1;
        hold_left  = 200;
        for (int n = 0; n < 12; n++) begin
            send_item(n[0] ? CMD_FREE : CMD_ALLOC, pick_free_target());
        end
        send_quiet = 1'b0;
        stop_sending();
    endtask

    // Allocate until every identifier is used, then check the full-map
    // refusal and reuse at the top, middle and bottom of the space.
    task automatic test_fill_bitmap();
        for (int n = 0; n < NUM_IDS; n++) send_item(CMD_ALLOC, ID_W'($urandom));
        send_item(CMD_ALLOC, '0);           // full
        send_item(CMD_ALLOC, '1);           // still full
        send_item(CMD_FREE, '1);
        send_item(CMD_ALLOC, '0);           // -> top identifier, last word
        send_item(CMD_FREE, 10'd640);
        send_item(CMD_ALLOC, '0);           // -> 640
        send_item(CMD_FREE, '0);
        send_item(CMD_ALLOC, '0);           // -> 0
        send_item(CMD_ALLOC, '0);           // full again
        stop_sending();
    endtask

    // Random mix starting from a full map: free-heavy first to open holes
    // across all words, then balanced, then allocate-heavy.
    task automatic test_random_mix();
        int   alloc_pct;
        logic cmd;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            send_quiet = (n % 50) >= 40;
            recv_quiet = (n % 60) >= 48;
            alloc_pct  = (n < 40) ? 15 : (n < 70) ? 50 : 80;
            cmd = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
            send_item(cmd, pick_free_target());
        end
        send_quiet = 1'b0;
        recv_quiet = 1'b0;
        stop_sending();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        in_valid    = 1'b0;
        command     = CMD_ALLOC;
        logic_id    = '0;
        out_stall   = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        send_quiet  = 1'b0;
        recv_quiet  = 1'b0;
        hold_left   = 0;
        foreach (id_used[i]) id_used[i] = 1'b0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_backpressure();
        test_fill_bitmap();
        test_random_mix();

        // Let every outstanding result arrive, then a little longer to catch strays.
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
